// ===== hdl/gbau_pkg.sv =====
package gbau_pkg;

    localparam logic [8:0] MAX_GLYPH_DIM = 9'd256;

    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;

    localparam logic [1:0] FMT_MONO  = 2'd0;
    localparam logic [1:0] FMT_GRAY2 = 2'd1;
    localparam logic [1:0] FMT_GRAY4 = 2'd2;
    localparam logic [1:0] FMT_GRAY8 = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic glyph_done;
        logic out_free;
        logic word_last;
    } status_t;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic [8:0] glyph_width;
        logic [8:0] glyph_height;
    } cfg_t;

    function automatic logic [8:0] clamp_dim(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0)
        begin
            r = 9'd1;
        end
        else if (v > MAX_GLYPH_DIM)
        begin
            r = MAX_GLYPH_DIM;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [7:0] scale_alpha(input logic [1:0] fmt, input logic [7:0] val);
        logic [7:0] r;
        unique case (fmt)
            FMT_MONO:  r = val[0] ? 8'd255 : 8'd0;
            FMT_GRAY2: r = (val[7:2] != 6'd0) ? 8'd255 : {val[1:0], 6'd0};
            FMT_GRAY4: r = (val[7:4] != 4'd0) ? 8'd255 : {val[3:0], 4'd0};
            FMT_GRAY8: r = (val[7:6] != 2'd0) ? 8'd255 : {val[5:0], 2'd0};
            default:   r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/gbau_cfg.sv =====
module gbau_cfg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [8:0]      cfg_data,
    output gbau_pkg::cfg_t  cfg
);

    logic [1:0] fmt_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= gbau_pkg::FMT_MONO;
            width_reg  <= 9'd1;
            height_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbau_pkg::REG_PIXEL_FORMAT: fmt_reg    <= cfg_data[1:0];
                gbau_pkg::REG_GLYPH_WIDTH:  width_reg  <= cfg_data;
                gbau_pkg::REG_GLYPH_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.pixel_format = fmt_reg;
    assign cfg.glyph_width  = gbau_pkg::clamp_dim(width_reg);
    assign cfg.glyph_height = gbau_pkg::clamp_dim(height_reg);

endmodule

// ===== hdl/gbau_ctrl.sv =====
module gbau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                start_glyph,
    input  gbau_pkg::status_t   status,
    output logic                s_tready,
    output gbau_pkg::cmd_t      cmd
);

    gbau_pkg::state_t state_reg;
    gbau_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbau_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbau_pkg::ST_IDLE:
            begin
                if (s_tvalid && (start_glyph || !status.glyph_done))
                begin
                    state_next = gbau_pkg::ST_RUN;
                end
            end
            gbau_pkg::ST_RUN:
            begin
                if (status.out_free && status.word_last)
                begin
                    state_next = gbau_pkg::ST_IDLE;
                end
            end
            default: state_next = gbau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        unique case (state_reg)
            gbau_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            gbau_pkg::ST_RUN:
            begin
                cmd.step = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/gbau_datapath.sv =====
module gbau_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gbau_pkg::cfg_t      cfg,
    input  gbau_pkg::cmd_t      cmd,
    input  logic [31:0]         glyph_word,
    input  logic                start_glyph,
    input  logic                m_tready,
    output gbau_pkg::status_t   status,
    output logic                m_tvalid,
    output logic [23:0]         m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic [31:0] word_reg;
    logic [5:0]  bits_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic        done_reg;
    logic        out_valid_reg;
    logic [7:0]  alpha_reg;
    logic [7:0]  out_col_reg;
    logic [7:0]  out_row_reg;
    logic        out_wlast_reg;
    logic        out_glast_reg;

    logic        mono;
    logic [7:0]  pix_val;
    logic [31:0] word_shift;
    logic [5:0]  bits_left;
    logic        bits_last;
    logic        row_end;
    logic        glyph_end;

    always_comb
    begin
        mono = (cfg.pixel_format == gbau_pkg::FMT_MONO);
        if (mono)
        begin
            pix_val    = {7'd0, word_reg[31]};
            word_shift = {word_reg[30:0], 1'b0};
            bits_left  = bits_reg - 6'd1;
            bits_last  = (bits_reg == 6'd1);
        end
        else
        begin
            pix_val    = word_reg[31:24];
            word_shift = {word_reg[23:0], 8'd0};
            bits_left  = bits_reg - 6'd8;
            bits_last  = (bits_reg <= 6'd15);
        end
        row_end   = ({1'b0, col_reg} + 9'd1) >= cfg.glyph_width;
        glyph_end = row_end && (({1'b0, row_reg} + 9'd1) >= cfg.glyph_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            bits_reg      <= 6'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                bits_reg <= 6'd32;
                if (start_glyph)
                begin
                    col_reg  <= 8'd0;
                    row_reg  <= 8'd0;
                    done_reg <= 1'b0;
                end
            end
            else if (cmd.step)
            begin
                bits_reg <= bits_left;
                if (row_end)
                begin
                    col_reg <= 8'd0;
                    if (glyph_end)
                    begin
                        row_reg  <= 8'd0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_reg + 8'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 8'd1;
                end
            end

            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= glyph_word;
        end
        else if (cmd.step)
        begin
            word_reg <= word_shift;
        end
        if (cmd.step)
        begin
            alpha_reg     <= gbau_pkg::scale_alpha(cfg.pixel_format, pix_val);
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_wlast_reg <= row_end || bits_last;
            out_glast_reg <= glyph_end;
        end
    end

    assign status.glyph_done = done_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.word_last  = row_end || bits_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, alpha_reg};
    assign m_tlast  = out_glast_reg;
    assign m_tuser  = out_wlast_reg;

endmodule

// ===== hdl/glyph_bitmap_alpha_unpacker_unit.sv =====
// Glyph bitmap to alpha unpacker.
// Input stream: one 32-bit bitmap word per transfer, first bitmap byte in
// bits 31..24; s_tuser set marks the first word of a glyph.
// Output stream: one transfer per pixel, alpha, column and row in m_tdata,
// m_tlast on the final pixel of the glyph, m_tuser on the last pixel taken
// from the current word.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 pixel
// format, 1 glyph width, 2 glyph height); write only while idle.
// Timing: a taken word is held in the word register, and each of its pixels
// is registered in the output register before it is valid on the output.
// Throughput: one pixel per cycle within a word while the receiver is ready;
// a word is loaded and then shifted out one pixel at a time, a full mono
// word yielding 32 pixels and a gray word at most 4. Words that yield no
// pixel are taken while idle and dropped.
// Reset: configuration returns to mono, width 1, height 1, and no glyph is
// active, so words without the start flag are dropped.
// Stall: a low m_tready holds the current pixel and pauses unpacking; the
// next word is taken only after the last pixel of the current word is
// registered.
module glyph_bitmap_alpha_unpacker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // glyph_word[31:0]
    input  logic        s_tuser,   // start_glyph
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_alpha[7:0], pixel_column[15:8], pixel_row[23:16]
    output logic        m_tlast,   // last_of_glyph
    output logic        m_tuser    // last_of_word
);

    gbau_pkg::cfg_t    cfg;
    gbau_pkg::cmd_t    cmd;
    gbau_pkg::status_t status;

    gbau_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbau_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .start_glyph (s_tuser),
        .status      (status),
        .s_tready    (s_tready),
        .cmd         (cmd)
    );

    gbau_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .glyph_word  (s_tdata),
        .start_glyph (s_tuser),
        .m_tready    (m_tready),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
